// ===== rtl/core/fbp_pkg.sv =====
package fbp_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned MAX_CHUNKS = 16;

  localparam int unsigned IDX_W    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned CHUNK_W  = $clog2(MAX_CHUNKS) + 1;
  localparam int unsigned BYTES_W  = 13;
  localparam int unsigned PER_W    = 7;
  localparam int unsigned OFS_W    = 18;
  localparam int unsigned QUOT_W   = 4;
  localparam int unsigned REM_W    = 6;
  localparam int unsigned CFG_W    = BYTES_W;

  localparam logic [BYTES_W-1:0] BYTES_MAX   = BYTES_W'(4096);
  localparam logic [PER_W-1:0]   PER_MAX     = PER_W'(64);
  localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(8);
  localparam logic [PER_W-1:0]   PER_RESET   = PER_W'(4);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOCATE = 2'd2
  } fbp_kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } fbp_status_e;

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_PER_CHUNK   = 2'd1,
    CFG_GROW_EN     = 2'd2
  } fbp_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAP,
    S_EXEC,
    S_GROW,
    S_POP,
    S_DIV,
    S_MUL,
    S_DONE
  } fbp_state_e;

  typedef struct packed {
    logic accept;
    logic cap;
    logic exec;
    logic grow;
    logic pop;
    logic div;
    logic mul;
  } fbp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       depth_zero;
    logic       alloc_exh;
    logic       loc_ok;
    logic       grow_last;
    logic       div_last;
  } fbp_sts_t;

endpackage

// ===== rtl/core/free_list_block_pool_core.sv =====
// Fixed-size block pool: hands out block indices from a LIFO free stack
// held in a 1024 x 10 single-port-write, registered-read memory.
// Request channel: drive kind_i and block_index_i with start high; the
// word is taken at a rising edge where start is high and busy is low.
// Kinds: allocate pops (growing the pool by one chunk if the stack is empty,
// growth is allowed or no chunk exists, and the chunk and pool limits hold),
// free pushes after a range check, locate returns chunk number and byte offset.
// Result channel: result_valid_o is high for exactly one cycle with all
// result fields; the receiver cannot stall, so it must take the word then.
// Steps from the accepting edge to the strobe, after capture and execute:
//   free, rejected request, unused kind : straight to the strobe
//   allocate from a non-empty stack     : stack read, then pop
//   allocate that adds a chunk          : a stack write for each block of
//                                         the chunk, one per cycle, then execute again and pop
//   successful locate                   : 4-step divider, then a
//                                         multiply step
// A new word can be taken in the strobe cycle, but not while busy.
// Config channel: cfg_ready_o is always high; write only between requests.
// Reset clears the stack depth and chunk count and loads the register
// defaults; stack contents are not cleared, and nothing reads them unwritten.
module free_list_block_pool_core import fbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic [IDX_W-1:0]    block_index_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic [QUOT_W-1:0]   chunk_number_o,
  output logic [OFS_W-1:0]    byte_offset_o,
  output logic [CNT_W-1:0]    free_count_o,
  output logic [CNT_W-1:0]    capacity_o
);

  fbp_cmd_t cmd;
  fbp_sts_t sts;

  // sequencer: one request at a time
  fbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (result_valid_o)
  );

  // stack memory, counters, divider and offset multiplier
  fbp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .block_index_i   (block_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_ready_o     (cfg_ready_o),
    .sts_o           (sts),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .chunk_number_o  (chunk_number_o),
    .byte_offset_o   (byte_offset_o),
    .free_count_o    (free_count_o),
    .capacity_o      (capacity_o)
  );

endmodule

// ===== rtl/core/fbp_ctrl.sv =====
module fbp_ctrl import fbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  fbp_sts_t sts_i,
  output fbp_cmd_t cmd_o,
  output logic     busy,
  output logic     done_o
);

  fbp_state_e state_q, state_d;
  logic       accept;

  assign busy   = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_DONE: begin
        state_d = accept ? S_CAP : S_IDLE;
      end
      S_CAP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (sts_i.kind)
          KIND_ALLOC: begin
            if (!sts_i.depth_zero) state_d = S_POP;
            else if (sts_i.alloc_exh) state_d = S_DONE;
            else state_d = S_GROW;
          end
          KIND_LOCATE: begin
            state_d = sts_i.loc_ok ? S_DIV : S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_GROW: begin
        // re-run the request once the new chunk is on the stack
        if (sts_i.grow_last) state_d = S_EXEC;
      end
      S_POP: begin
        state_d = S_DONE;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.cap    = (state_q == S_CAP);
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.grow   = (state_q == S_GROW);
    cmd_o.pop    = (state_q == S_POP);
    cmd_o.div    = (state_q == S_DIV);
    cmd_o.mul    = (state_q == S_MUL);
    done_o       = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/fbp_dp.sv =====
module fbp_dp import fbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbp_cmd_t            cmd_i,
  input  logic [1:0]          kind_i,
  input  logic [IDX_W-1:0]    block_index_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic                cfg_ready_o,
  output fbp_sts_t            sts_o,
  output logic [1:0]          status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic [QUOT_W-1:0]   chunk_number_o,
  output logic [OFS_W-1:0]    byte_offset_o,
  output logic [CNT_W-1:0]    free_count_o,
  output logic [CNT_W-1:0]    capacity_o
);

  // configuration
  logic [BYTES_W-1:0] bytes_q;
  logic [PER_W-1:0]   per_q;
  logic               grow_en_q;
  logic [BYTES_W-1:0] bytes_eff;
  logic [PER_W-1:0]   per_eff;

  // request and pool state
  logic [1:0]         kind_q;
  logic [IDX_W-1:0]   idx_q;
  logic [CNT_W-1:0]   depth_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [CNT_W-1:0]   cap_q;
  logic [REM_W-1:0]   grow_cnt_q;
  logic [IDX_W-1:0]   rem_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [1:0]         bit_q;

  // results
  fbp_status_e        res_status_q;
  logic [IDX_W-1:0]   res_granted_q;
  logic [QUOT_W-1:0]  res_chunk_q;
  logic [OFS_W-1:0]   res_offset_q;

  // free stack
  logic [IDX_W-1:0]   mem [MAX_BLOCKS];
  logic [IDX_W-1:0]   rd_data_q;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   pop_addr;

  logic [CNT_W-1:0]     cap_prod;
  logic [CNT_W:0]       grow_sum;
  logic [IDX_W-1:0]     grow_data;
  logic [CNT_W-1:0]     trial;
  logic [OFS_W-1:0]     ofs_prod;
  logic                 depth_zero;
  logic                 in_range;
  logic                 stack_full;
  logic                 alloc_exh;
  logic                 free_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (bytes_q == '0) bytes_eff = BYTES_W'(1);
    else if (bytes_q > BYTES_MAX) bytes_eff = BYTES_MAX;
    else bytes_eff = bytes_q;
    if (per_q == '0) per_eff = PER_W'(1);
    else if (per_q > PER_MAX) per_eff = PER_MAX;
    else per_eff = per_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q   <= BYTES_RESET;
      per_q     <= PER_RESET;
      grow_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BLOCK_BYTES: bytes_q   <= cfg_data_i;
        CFG_PER_CHUNK:   per_q     <= cfg_data_i[PER_W-1:0];
        CFG_GROW_EN:     grow_en_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // chunk count times chunk size never exceeds the pool size
  assign cap_prod   = CNT_W'(chunk_q) * CNT_W'(per_eff);
  assign grow_sum   = {1'b0, cap_q} + (CNT_W+1)'(per_eff);
  // a chunk is only added below the pool size, so the sum fits an index
  assign grow_data  = cap_q[IDX_W-1:0] + IDX_W'(grow_cnt_q);
  assign trial      = CNT_W'(per_eff) << bit_q;
  assign ofs_prod   = OFS_W'(rem_q[REM_W-1:0]) * OFS_W'(bytes_eff);
  assign depth_zero = (depth_q == '0);
  assign in_range   = (CNT_W'(idx_q) < cap_q);
  assign stack_full = (depth_q == CNT_W'(MAX_BLOCKS));
  assign free_ok    = in_range && !stack_full;
  assign alloc_exh  = depth_zero &&
                      ((!grow_en_q && (chunk_q != '0)) ||
                       (chunk_q >= CHUNK_W'(MAX_CHUNKS)) ||
                       (grow_sum > (CNT_W+1)'(MAX_BLOCKS)));

  assign sts_o.kind       = kind_q;
  assign sts_o.depth_zero = depth_zero;
  assign sts_o.alloc_exh  = alloc_exh;
  assign sts_o.loc_ok     = in_range;
  assign sts_o.grow_last  = ({1'b0, grow_cnt_q} == (per_eff - PER_W'(1)));
  assign sts_o.div_last   = (bit_q == '0);

  assign mem_we    = cmd_i.grow || (cmd_i.exec && (kind_q == KIND_FREE) && free_ok);
  assign mem_re    = cmd_i.exec && (kind_q == KIND_ALLOC) && !depth_zero;
  assign mem_wdata = cmd_i.grow ? grow_data : idx_q;
  assign pop_addr  = depth_q[IDX_W-1:0] - IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[depth_q[IDX_W-1:0]] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[pop_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      idx_q  <= block_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      chunk_q    <= '0;
      cap_q      <= '0;
      grow_cnt_q <= '0;
      rem_q      <= '0;
      quot_q     <= '0;
      bit_q      <= '0;
    end else begin
      if (cmd_i.cap) cap_q <= cap_prod;
      if (cmd_i.exec) begin
        case (kind_q)
          KIND_ALLOC: begin
            if (!depth_zero) depth_q <= depth_q - CNT_W'(1);
            else grow_cnt_q <= '0;
          end
          KIND_FREE: begin
            if (free_ok) depth_q <= depth_q + CNT_W'(1);
          end
          KIND_LOCATE: begin
            rem_q  <= idx_q;
            quot_q <= '0;
            bit_q  <= 2'd3;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.grow) begin
        depth_q    <= depth_q + CNT_W'(1);
        grow_cnt_q <= grow_cnt_q + REM_W'(1);
        if (sts_o.grow_last) begin
          chunk_q <= chunk_q + CHUNK_W'(1);
          cap_q   <= grow_sum[CNT_W-1:0];
        end
      end
      if (cmd_i.div) begin
        // restoring division, one quotient bit per step
        if (CNT_W'(rem_q) >= trial) begin
          rem_q          <= rem_q - trial[IDX_W-1:0];
          quot_q[bit_q]  <= 1'b1;
        end
        bit_q <= bit_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_granted_q <= '0;
      res_chunk_q   <= '0;
      res_offset_q  <= '0;
      case (kind_q)
        KIND_ALLOC:  res_status_q <= alloc_exh ? STAT_EXHAUSTED : STAT_OK;
        KIND_FREE: begin
          if (!in_range) res_status_q <= STAT_RANGE;
          else if (stack_full) res_status_q <= STAT_FULL;
          else res_status_q <= STAT_OK;
        end
        KIND_LOCATE: res_status_q <= in_range ? STAT_OK : STAT_RANGE;
        default:     res_status_q <= STAT_OK;
      endcase
    end
    if (cmd_i.pop) res_granted_q <= rd_data_q;
    if (cmd_i.mul) begin
      res_chunk_q  <= quot_q;
      res_offset_q <= ofs_prod;
    end
  end

  assign status_o        = res_status_q;
  assign granted_index_o = res_granted_q;
  assign chunk_number_o  = res_chunk_q;
  assign byte_offset_o   = res_offset_q;
  assign free_count_o    = depth_q;
  assign capacity_o      = cap_q;

endmodule

// ===== rtl/core/fbp_checker.sv =====
module fbp_checker import fbp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input logic [1:0]          status_o,
  input logic [IDX_W-1:0]    granted_index_o,
  input logic [QUOT_W-1:0]   chunk_number_o,
  input logic [OFS_W-1:0]    byte_offset_o,
  input logic [CNT_W-1:0]    free_count_o,
  input logic [CNT_W-1:0]    capacity_o
);

  // no result strobe directly follows an accepting edge
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobe too soon after accept");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while a result is shown");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != STAT_OK)) |->
      ((granted_index_o == '0) && (chunk_number_o == '0) && (byte_offset_o == '0)))
    else $error("failed request returned nonzero fields");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((free_count_o <= CNT_W'(MAX_BLOCKS)) &&
                        (capacity_o <= CNT_W'(MAX_BLOCKS))))
    else $error("count above pool size");

endmodule

bind free_list_block_pool_core fbp_checker u_fbp_checker (.*);
